>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and idle during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold in the same cycle.
`define SGRAP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgrap assertion failed");

// Implication checked in the cycle after the antecedent.
`define SGRAP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgrap assertion failed");

`endif

>>> hw/rtl/sgrap_pkg.sv
// ---------------------------------------------------------------------------
// sgrap_pkg
// Types, codes and pen update functions of the SGR attribute parser.
// ---------------------------------------------------------------------------
`default_nettype none

package sgrap_pkg;

  localparam int PARAM_WIDTH_DEF = 16;
  localparam int IN_TDATA_W      = 16;
  localparam int CODE_W          = 16;
  localparam int OUT_TDATA_W     = 56;
  localparam int OUT_PAYLOAD_W   = 54;
  localparam int OUT_PAD_W       = OUT_TDATA_W - OUT_PAYLOAD_W;
  localparam int OUT_TUSER_W     = 4;

  typedef logic [CODE_W-1:0] code_t;

  // SGR codes
  localparam code_t CODE_RESET       = 16'd0;
  localparam code_t CODE_BOLD        = 16'd1;
  localparam code_t CODE_ITALIC      = 16'd3;
  localparam code_t CODE_UNDERLINE   = 16'd4;
  localparam code_t CODE_BLINK_SLOW  = 16'd5;
  localparam code_t CODE_BLINK_FAST  = 16'd6;
  localparam code_t CODE_INVERSE     = 16'd7;
  localparam code_t CODE_STRIKE      = 16'd9;
  localparam code_t CODE_NO_BOLD     = 16'd21;
  localparam code_t CODE_NORMAL      = 16'd22;
  localparam code_t CODE_NO_ITALIC   = 16'd23;
  localparam code_t CODE_NO_UNDER    = 16'd24;
  localparam code_t CODE_NO_BLINK    = 16'd25;
  localparam code_t CODE_NO_INVERSE  = 16'd27;
  localparam code_t CODE_NO_STRIKE   = 16'd29;
  localparam code_t CODE_FG_BASE     = 16'd30;
  localparam code_t CODE_FG_TOP      = 16'd37;
  localparam code_t CODE_FG_EXT      = 16'd38;
  localparam code_t CODE_FG_DEFAULT  = 16'd39;
  localparam code_t CODE_BG_BASE     = 16'd40;
  localparam code_t CODE_BG_TOP      = 16'd47;
  localparam code_t CODE_BG_EXT      = 16'd48;
  localparam code_t CODE_BG_DEFAULT  = 16'd49;
  localparam code_t CODE_FG_BRIGHT   = 16'd90;
  localparam code_t CODE_FG_BRT_TOP  = 16'd97;
  localparam code_t CODE_BG_BRIGHT   = 16'd100;
  localparam code_t CODE_BG_BRT_TOP  = 16'd107;
  localparam code_t BRIGHT_OFFSET    = 16'd8;
  localparam code_t SUB_PALETTE      = 16'd5;
  localparam code_t SUB_RGB          = 16'd2;

  // Style bit positions
  localparam int STY_BOLD      = 0;
  localparam int STY_ITALIC    = 1;
  localparam int STY_UNDERLINE = 2;
  localparam int STY_BLINK     = 3;
  localparam int STY_INVERSE   = 4;
  localparam int STY_STRIKE    = 5;

  typedef enum logic [1:0] {
    KIND_DEFAULT = 2'd0,
    KIND_PALETTE = 2'd1,
    KIND_RGB     = 2'd2
  } colour_kind_t;

  typedef struct packed {
    colour_kind_t kind;
    logic [7:0]   c0;
    logic [7:0]   c1;
    logic [7:0]   c2;
  } colour_t;

  typedef struct packed {
    logic [5:0] style;
    colour_t    fg;
    colour_t    bg;
  } pen_t;

  localparam colour_t COLOUR_DEFAULT = '{kind: KIND_DEFAULT, c0: 8'd0, c1: 8'd0, c2: 8'd0};
  localparam pen_t    PEN_RESET      = '{style: 6'd0, fg: COLOUR_DEFAULT, bg: COLOUR_DEFAULT};

  // Progress through a 38/48 extended colour form
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SUB   = 3'd1,
    PH_PAL   = 3'd2,
    PH_RED   = 3'd3,
    PH_GREEN = 3'd4,
    PH_BLUE  = 3'd5
  } ext_phase_t;

  typedef enum logic [2:0] {
    ST_RUN  = 3'd0,
    ST_FIN  = 3'd1,
    ST_REP1 = 3'd2,
    ST_REP2 = 3'd3,
    ST_EMIT = 3'd4
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_NONE         = 3'd0,
    OP_STEP         = 3'd1,
    OP_CLEAR        = 3'd2,
    OP_TRUNC        = 3'd3,
    OP_REPLAY_RED   = 3'd4,
    OP_REPLAY_GREEN = 3'd5
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   load_out;
  } dp_cmd_t;

  typedef struct packed {
    ext_phase_t phase;
  } dp_stat_t;

  function automatic colour_t palette_colour(logic [7:0] idx);
    colour_t c;
    c = '{kind: KIND_PALETTE, c0: idx, c1: 8'd0, c2: 8'd0};
    return c;
  endfunction

  function automatic pen_t set_ext(pen_t p, logic bg, colour_t c);
    pen_t q;
    q = p;
    if (bg) begin
      q.bg = c;
    end else begin
      q.fg = c;
    end
    return q;
  endfunction

  // Every code except the extended colour introducers.
  function automatic pen_t plain_code(pen_t p, code_t v);
    pen_t q;
    q = p;
    unique case (v) inside
      CODE_RESET:                       q = PEN_RESET;
      CODE_BOLD:                        q.style[STY_BOLD] = 1'b1;
      CODE_ITALIC:                      q.style[STY_ITALIC] = 1'b1;
      CODE_UNDERLINE:                   q.style[STY_UNDERLINE] = 1'b1;
      CODE_BLINK_SLOW, CODE_BLINK_FAST: q.style[STY_BLINK] = 1'b1;
      CODE_INVERSE:                     q.style[STY_INVERSE] = 1'b1;
      CODE_STRIKE:                      q.style[STY_STRIKE] = 1'b1;
      CODE_NO_BOLD, CODE_NORMAL:        q.style[STY_BOLD] = 1'b0;
      CODE_NO_ITALIC:                   q.style[STY_ITALIC] = 1'b0;
      CODE_NO_UNDER:                    q.style[STY_UNDERLINE] = 1'b0;
      CODE_NO_BLINK:                    q.style[STY_BLINK] = 1'b0;
      CODE_NO_INVERSE:                  q.style[STY_INVERSE] = 1'b0;
      CODE_NO_STRIKE:                   q.style[STY_STRIKE] = 1'b0;
      [CODE_FG_BASE:CODE_FG_TOP]:       q.fg = palette_colour(8'(v - CODE_FG_BASE));
      CODE_FG_DEFAULT:                  q.fg = COLOUR_DEFAULT;
      [CODE_BG_BASE:CODE_BG_TOP]:       q.bg = palette_colour(8'(v - CODE_BG_BASE));
      CODE_BG_DEFAULT:                  q.bg = COLOUR_DEFAULT;
      [CODE_FG_BRIGHT:CODE_FG_BRT_TOP]:
        q.fg = palette_colour(8'(v - CODE_FG_BRIGHT + BRIGHT_OFFSET));
      [CODE_BG_BRIGHT:CODE_BG_BRT_TOP]:
        q.bg = palette_colour(8'(v - CODE_BG_BRIGHT + BRIGHT_OFFSET));
      default: ;
    endcase
    return q;
  endfunction

  // A buffered code replayed at sequence end: an introducer there can no
  // longer complete, so it falls back to the default colour.
  function automatic pen_t replay_code(pen_t p, code_t v);
    pen_t q;
    if (v == CODE_FG_EXT) begin
      q = set_ext(p, 1'b0, COLOUR_DEFAULT);
    end else if (v == CODE_BG_EXT) begin
      q = set_ext(p, 1'b1, COLOUR_DEFAULT);
    end else begin
      q = plain_code(p, v);
    end
    return q;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sgr_attribute_parser.sv
// Words that do not end a sequence are taken one per cycle.
// A last word gives its pen on out_tvalid via ST_FIN and ST_EMIT, which loads the
// output register; an RGB form cut off after its red or green word first replays
// one or two of them; an empty sequence skips ST_FIN; a held result stalls ST_EMIT.
// Input is held off from a sequence end until the pen is in the output register.
// Reset (synchronous, rst_n low) gives a plain pen and no pending extended form.
// ---------------------------------------------------------------------------
// sgr_attribute_parser
// Applies SGR parameter words to a kept pen and emits the pen at sequence end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sgr_attribute_parser
  import sgrap_pkg::*;
#(
  parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [15:0] param_value
  input  wire logic                   in_tlast,   // last_param
  input  wire logic                   in_tuser,   // empty_sequence
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [5:0] style_bits, [13:6] fg_red_or_index, [21:14] fg_green,
  // [29:22] fg_blue, [37:30] bg_red_or_index, [45:38] bg_green,
  // [53:46] bg_blue, [55:54] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [OUT_TUSER_W-1:0]      out_tuser   // [1:0] fg_kind, [3:2] bg_kind
);

  dp_cmd_t  cmd;
  dp_stat_t stat;
  pen_t     out_pen;

  sgrap_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  sgrap_dp #(
    .PARAM_WIDTH (PARAM_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_value (in_tdata[PARAM_WIDTH-1:0]),
    .stat     (stat),
    .out_pen  (out_pen)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}},
                      out_pen.bg.c2, out_pen.bg.c1, out_pen.bg.c0,
                      out_pen.fg.c2, out_pen.fg.c1, out_pen.fg.c0,
                      out_pen.style};
  assign out_tuser = {out_pen.bg.kind, out_pen.fg.kind};

  // No word is taken while buffered codes are being replayed.
  `SGRAP_ASSERT_IMP(a_no_accept_in_replay, cmd.op == OP_REPLAY_RED || cmd.op == OP_REPLAY_GREEN, !in_tready)
  // An empty sequence drops any pending extended form.
  `SGRAP_ASSERT_NXT(a_empty_drops_ext, in_tvalid && in_tready && in_tuser, stat.phase == PH_IDLE)
  // Closing a cut-off extended form always leaves the tracker idle.
  `SGRAP_ASSERT_NXT(a_trunc_idles, cmd.op == OP_TRUNC, stat.phase == PH_IDLE)
  // A result appears only after the pen was copied to the output register.
  `SGRAP_ASSERT_IMP(a_valid_after_load, $rose(out_tvalid), $past(cmd.load_out))

endmodule

`default_nettype wire

>>> hw/rtl/sgrap_dp.sv
// ---------------------------------------------------------------------------
// sgrap_dp
// Datapath: pen registers, extended form tracking, buffered sub-parameters
// and the output pen register.
// ---------------------------------------------------------------------------
`default_nettype none

module sgrap_dp
  import sgrap_pkg::*;
#(
  parameter int PARAM_WIDTH = PARAM_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dp_cmd_t                cmd,
  input  wire logic [PARAM_WIDTH-1:0] in_value,
  output dp_stat_t                    stat,
  output pen_t                        out_pen
);

  pen_t                   pen_r, pen_nxt;
  ext_phase_t             phase_r, phase_nxt;
  logic                   ext_bg_r, ext_bg_nxt;
  logic [PARAM_WIDTH-1:0] red_r, red_nxt;
  logic [PARAM_WIDTH-1:0] green_r, green_nxt;
  pen_t                   out_pen_r;

  code_t v16;
  pen_t  base_pen;
  pen_t  code_pen;
  logic  is_ext;
  logic  do_code;

  assign v16      = CODE_W'(in_value);
  assign is_ext   = (v16 == CODE_FG_EXT) || (v16 == CODE_BG_EXT);
  // A bad sub-type first drops the pending colour, then counts as a code.
  assign base_pen = (phase_r == PH_SUB) ? set_ext(pen_r, ext_bg_r, COLOUR_DEFAULT) : pen_r;
  assign code_pen = plain_code(base_pen, v16);

  always_comb begin
    pen_nxt    = pen_r;
    phase_nxt  = phase_r;
    ext_bg_nxt = ext_bg_r;
    red_nxt    = red_r;
    green_nxt  = green_r;
    do_code    = 1'b0;
    unique case (cmd.op)
      OP_NONE: ;
      OP_CLEAR: begin
        pen_nxt   = PEN_RESET;
        phase_nxt = PH_IDLE;
      end
      OP_STEP: begin
        unique case (phase_r)
          PH_IDLE: do_code = 1'b1;
          PH_SUB: begin
            if (v16 == SUB_PALETTE) begin
              phase_nxt = PH_PAL;
            end else if (v16 == SUB_RGB) begin
              phase_nxt = PH_RED;
            end else begin
              do_code = 1'b1;
            end
          end
          PH_PAL: begin
            pen_nxt   = set_ext(pen_r, ext_bg_r, palette_colour(in_value[7:0]));
            phase_nxt = PH_IDLE;
          end
          PH_RED: begin
            red_nxt   = in_value;
            phase_nxt = PH_GREEN;
          end
          PH_GREEN: begin
            green_nxt = in_value;
            phase_nxt = PH_BLUE;
          end
          PH_BLUE: begin
            pen_nxt   = set_ext(pen_r, ext_bg_r,
                                '{kind: KIND_RGB, c0: red_r[7:0], c1: green_r[7:0],
                                  c2: in_value[7:0]});
            phase_nxt = PH_IDLE;
          end
          default: do_code = 1'b1;
        endcase
        if (do_code) begin
          if (is_ext) begin
            pen_nxt    = base_pen;
            phase_nxt  = PH_SUB;
            ext_bg_nxt = (v16 == CODE_BG_EXT);
          end else begin
            pen_nxt   = code_pen;
            phase_nxt = PH_IDLE;
          end
        end
      end
      OP_TRUNC: begin
        pen_nxt = set_ext(pen_r, ext_bg_r, COLOUR_DEFAULT);
        // The buffered palette sub-type replays as the blink code.
        if (phase_r == PH_PAL) begin
          pen_nxt.style[STY_BLINK] = 1'b1;
        end
        phase_nxt = PH_IDLE;
      end
      OP_REPLAY_RED:   pen_nxt = replay_code(pen_r, CODE_W'(red_r));
      OP_REPLAY_GREEN: pen_nxt = replay_code(pen_r, CODE_W'(green_r));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r    <= PEN_RESET;
      phase_r  <= PH_IDLE;
      ext_bg_r <= 1'b0;
    end else begin
      pen_r    <= pen_nxt;
      phase_r  <= phase_nxt;
      ext_bg_r <= ext_bg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r   <= red_nxt;
    green_r <= green_nxt;
    if (cmd.load_out) begin
      out_pen_r <= pen_r;
    end
  end

  assign stat.phase = phase_r;
  assign out_pen    = out_pen_r;

endmodule

`default_nettype wire

>>> hw/rtl/sgrap_ctrl.sv
// ---------------------------------------------------------------------------
// sgrap_ctrl
// Controller: sequences word steps, sequence-end replay and result hand-off.
// ---------------------------------------------------------------------------
`default_nettype none

module sgrap_ctrl
  import sgrap_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  input  wire logic     in_tlast,
  input  wire logic     in_tuser,
  input  wire logic     out_tready,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd,
  output logic          in_tready,
  output logic          out_tvalid
);

  ctrl_state_t state_r, state_nxt;
  logic        rep_two_r, rep_two_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        out_free;

  assign out_free = !out_valid_r || out_tready;

  // Next state
  always_comb begin
    state_nxt   = state_r;
    rep_two_nxt = rep_two_r;
    unique case (state_r)
      ST_RUN: begin
        if (in_tvalid) begin
          if (in_tuser) begin
            state_nxt = ST_EMIT;
          end else if (in_tlast) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_FIN: begin
        rep_two_nxt = (stat.phase == PH_BLUE);
        if (stat.phase == PH_GREEN || stat.phase == PH_BLUE) begin
          state_nxt = ST_REP1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_REP1: state_nxt = rep_two_r ? ST_REP2 : ST_EMIT;
      ST_REP2: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

  // Outputs
  always_comb begin
    cmd.op       = OP_NONE;
    cmd.load_out = 1'b0;
    in_tready    = 1'b0;
    unique case (state_r)
      ST_RUN: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op = in_tuser ? OP_CLEAR : OP_STEP;
        end
      end
      ST_FIN: begin
        if (stat.phase != PH_IDLE) begin
          cmd.op = OP_TRUNC;
        end
      end
      ST_REP1: cmd.op = OP_REPLAY_RED;
      ST_REP2: cmd.op = OP_REPLAY_GREEN;
      ST_EMIT: cmd.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      rep_two_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rep_two_r   <= rep_two_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

>>> test/tb_sgr_attribute_parser.sv
// ---------------------------------------------------------------------------
// tb_sgr_attribute_parser
// Streams SGR parameter words into the parser and checks every emitted pen
// against a pen model kept in the bench. The directed tests cover style
// flags, palette and RGB forms, bad sub-types, cut-off extended forms and
// empty sequences. Random sequences, sender gaps, receiver stalls and one
// long output hold-off follow.
// ---------------------------------------------------------------------------
module tb_sgr_attribute_parser;
  import sgrap_pkg::*;

  localparam int LIMIT_CYCLES  = 200000;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD     = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // [15:0] param_value
  logic                   in_tlast = 1'b0; // last_param
  logic                   in_tuser = 1'b0; // empty_sequence
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [5:0] style_bits, [13:6] fg_red_or_index, [21:14] fg_green,
  // [29:22] fg_blue, [37:30] bg_red_or_index, [45:38] bg_green,
  // [53:46] bg_blue, [55:54] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;       // [1:0] fg_kind, [3:2] bg_kind

  sgr_attribute_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Pen model state.
  pen_t        pen_state = PEN_RESET;
  ext_phase_t  form_phase = PH_IDLE;
  logic        form_is_bg = 1'b0;
  logic [15:0] form_args [3];

  pen_t        expected_pens [$];
  logic [15:0] param_seq [$];
  pen_t        got_pen;
  int          mismatch_count = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  int          cycle_count = 0;

  // Receiver control.
  int          hold_asked = 0;
  int          hold_served = 0;
  int          stall_left = 0;
  int          rx_mode = 0;
  logic [5:0]  rx_cycle = '0;

  function automatic colour_t make_colour(colour_kind_t k, logic [15:0] a,
                                          logic [15:0] b, logic [15:0] c);
    colour_t col;
    col.kind = k;
    col.c0   = a[7:0];
    col.c1   = b[7:0];
    col.c2   = c[7:0];
    return col;
  endfunction

  function automatic void put_colour(logic bg, colour_t col);
    if (bg) begin
      pen_state.bg = col;
    end else begin
      pen_state.fg = col;
    end
  endfunction

  function automatic void apply_plain(logic [15:0] v);
    if (v == CODE_RESET) begin
      pen_state = PEN_RESET;
    end else if (v >= CODE_FG_BASE && v <= CODE_FG_TOP) begin
      put_colour(1'b0, make_colour(KIND_PALETTE, v - CODE_FG_BASE, 0, 0));
    end else if (v >= CODE_BG_BASE && v <= CODE_BG_TOP) begin
      put_colour(1'b1, make_colour(KIND_PALETTE, v - CODE_BG_BASE, 0, 0));
    end else if (v >= CODE_FG_BRIGHT && v <= CODE_FG_BRT_TOP) begin
      put_colour(1'b0, make_colour(KIND_PALETTE, v - CODE_FG_BRIGHT + BRIGHT_OFFSET, 0, 0));
    end else if (v >= CODE_BG_BRIGHT && v <= CODE_BG_BRT_TOP) begin
      put_colour(1'b1, make_colour(KIND_PALETTE, v - CODE_BG_BRIGHT + BRIGHT_OFFSET, 0, 0));
    end else begin
      case (v)
        CODE_BOLD:                        pen_state.style[STY_BOLD] = 1'b1;
        CODE_ITALIC:                      pen_state.style[STY_ITALIC] = 1'b1;
        CODE_UNDERLINE:                   pen_state.style[STY_UNDERLINE] = 1'b1;
        CODE_BLINK_SLOW, CODE_BLINK_FAST: pen_state.style[STY_BLINK] = 1'b1;
        CODE_INVERSE:                     pen_state.style[STY_INVERSE] = 1'b1;
        CODE_STRIKE:                      pen_state.style[STY_STRIKE] = 1'b1;
        CODE_NO_BOLD, CODE_NORMAL:        pen_state.style[STY_BOLD] = 1'b0;
        CODE_NO_ITALIC:                   pen_state.style[STY_ITALIC] = 1'b0;
        CODE_NO_UNDER:                    pen_state.style[STY_UNDERLINE] = 1'b0;
        CODE_NO_BLINK:                    pen_state.style[STY_BLINK] = 1'b0;
        CODE_NO_INVERSE:                  pen_state.style[STY_INVERSE] = 1'b0;
        CODE_NO_STRIKE:                   pen_state.style[STY_STRIKE] = 1'b0;
        CODE_FG_DEFAULT:                  pen_state.fg = COLOUR_DEFAULT;
        CODE_BG_DEFAULT:                  pen_state.bg = COLOUR_DEFAULT;
        default: ;
      endcase
    end
  endfunction

  function automatic void start_or_plain(logic [15:0] v);
    if (v == CODE_FG_EXT || v == CODE_BG_EXT) begin
      form_phase = PH_SUB;
      form_is_bg = (v == CODE_BG_EXT);
    end else begin
      apply_plain(v);
    end
  endfunction

  // Applies one accepted word to the model pen; returns 1 when a pen is due.
  function automatic bit predict_pen(logic [15:0] v, logic last, logic empty);
    logic bg;
    int   n;
    bg = form_is_bg;
    if (empty) begin
      pen_state  = PEN_RESET;
      form_phase = PH_IDLE;
      return 1'b1;
    end
    case (form_phase)
      PH_SUB: begin
        if (v == SUB_PALETTE) begin
          form_args[0] = v;
          form_phase   = PH_PAL;
        end else if (v == SUB_RGB) begin
          form_args[0] = v;
          form_phase   = PH_RED;
        end else begin
          put_colour(bg, COLOUR_DEFAULT);
          form_phase = PH_IDLE;
          start_or_plain(v);
        end
      end
      PH_PAL: begin
        put_colour(bg, make_colour(KIND_PALETTE, v, 0, 0));
        form_phase = PH_IDLE;
      end
      PH_RED: begin
        form_args[1] = v;
        form_phase   = PH_GREEN;
      end
      PH_GREEN: begin
        form_args[2] = v;
        form_phase   = PH_BLUE;
      end
      PH_BLUE: begin
        put_colour(bg, make_colour(KIND_RGB, form_args[1], form_args[2], v));
        form_phase = PH_IDLE;
      end
      default: begin
        form_phase = PH_IDLE;
        start_or_plain(v);
      end
    endcase
    if (!last) begin
      return 1'b0;
    end
    // A form cut off by the sequence end falls back to default, and the
    // buffered sub-parameters are then run as codes. An introducer among them
    // can no longer complete, so it only defaults its colour.
    if (form_phase != PH_IDLE) begin
      case (form_phase)
        PH_PAL, PH_RED: n = 1;
        PH_GREEN:       n = 2;
        PH_BLUE:        n = 3;
        default:        n = 0;
      endcase
      put_colour(form_is_bg, COLOUR_DEFAULT);
      form_phase = PH_IDLE;
      for (int i = 0; i < n; i++) begin
        if (form_args[i] == CODE_FG_EXT) begin
          put_colour(1'b0, COLOUR_DEFAULT);
        end else if (form_args[i] == CODE_BG_EXT) begin
          put_colour(1'b1, COLOUR_DEFAULT);
        end else begin
          apply_plain(form_args[i]);
        end
      end
    end
    return 1'b1;
  endfunction

  // Sends one word, with a random gap at the start of each burst, and updates
  // the pen model once the word is taken.
  task automatic send_word(input logic [15:0] value, input logic last, input logic empty);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    in_tuser  <= empty;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (predict_pen(value, last, empty)) begin
      expected_pens.push_back(pen_state);
    end
    words_sent++;
  endtask

  task automatic send_sequence(input bit with_noise);
    for (int i = 0; i < param_seq.size(); i++) begin
      // Now and then an empty sequence cuts in and drops what is pending.
      if (with_noise && $urandom_range(0, 39) == 0) begin
        send_word($urandom_range(0, 65535), $urandom_range(0, 1), 1'b1);
      end
      send_word(param_seq[i], i == param_seq.size() - 1, 1'b0);
    end
  endtask

  task automatic wait_for_pens();
    in_tvalid <= 1'b0;
    while (expected_pens.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 9))
      7:       return ($urandom_range(0, 1) == 1) ? CODE_FG_DEFAULT : CODE_BG_DEFAULT;
      8:       return $urandom_range(0, 65535);
      9:       return $urandom_range(CODE_NO_BOLD, CODE_NO_STRIKE);
      default: return $urandom_range(0, 110);
    endcase
  endfunction

  function automatic logic [15:0] colour_value();
    case ($urandom_range(0, 3))
      2:       return $urandom_range(0, 65535);
      3:       return pick_code();
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  function automatic logic [15:0] pick_introducer();
    return ($urandom_range(0, 1) == 1) ? CODE_BG_EXT : CODE_FG_EXT;
  endfunction

  // Builds a mostly well-formed parameter list with random content.
  task automatic build_sequence();
    int          r;
    logic [15:0] sub;
    param_seq.delete();
    repeat ($urandom_range(1, 4)) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        param_seq.push_back(pick_code());
      end else if (r < 60) begin
        param_seq.push_back(pick_introducer());
        param_seq.push_back(SUB_PALETTE);
        param_seq.push_back(colour_value());
      end else if (r < 80) begin
        param_seq.push_back(pick_introducer());
        param_seq.push_back(SUB_RGB);
        repeat (3) param_seq.push_back(colour_value());
      end else if (r < 90) begin
        param_seq.push_back(pick_introducer());
        do sub = pick_code(); while (sub == SUB_PALETTE || sub == SUB_RGB);
        param_seq.push_back(sub);
      end else begin
        param_seq.push_back($urandom_range(0, 65535));
      end
    end
    // Leave an extended form unfinished at the sequence end, cut at any phase.
    if ($urandom_range(0, 4) == 0) begin
      param_seq.push_back(pick_introducer());
      case ($urandom_range(0, 4))
        1: param_seq.push_back(SUB_PALETTE);
        2: param_seq.push_back(SUB_RGB);
        3: begin
          param_seq.push_back(SUB_RGB);
          param_seq.push_back(colour_value());
        end
        4: begin
          param_seq.push_back(SUB_RGB);
          param_seq.push_back(colour_value());
          param_seq.push_back(colour_value());
        end
        default: ;
      endcase
    end
  endtask

  task automatic test_empty_sequence();
    send_word(16'hFFFF, 1'b1, 1'b1);
    // An empty sequence drops a half-built RGB form, even without a last flag.
    send_word(CODE_FG_EXT, 1'b0, 1'b0);
    send_word(SUB_RGB, 1'b0, 1'b0);
    send_word(16'h0000, 1'b0, 1'b1);
  endtask

  task automatic test_style_and_palette();
    param_seq = '{CODE_BOLD, CODE_ITALIC, CODE_UNDERLINE, CODE_BLINK_FAST,
                  CODE_INVERSE, CODE_STRIKE, CODE_FG_BRT_TOP};
    send_sequence(1'b0);
  endtask

  task automatic test_extended_forms();
    param_seq = '{CODE_BG_EXT, SUB_RGB, 16'hFFFF, 16'd128, 16'd1};
    send_sequence(1'b0);
    param_seq = '{CODE_FG_EXT, SUB_PALETTE, 16'd300};
    send_sequence(1'b0);
  endtask

  task automatic test_broken_forms();
    // Bad sub-type: the colour defaults and the word counts as a code.
    param_seq = '{CODE_RESET, CODE_FG_EXT, CODE_INVERSE};
    send_sequence(1'b0);
    // RGB form cut after green: the red and green words are replayed.
    param_seq = '{CODE_BG_EXT, SUB_RGB, CODE_BG_EXT, CODE_STRIKE};
    send_sequence(1'b0);
  endtask

  task automatic test_random_sequences(input int word_budget);
    int first_word;
    int r;
    first_word = words_sent;
    while (words_sent - first_word < word_budget) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_word($urandom_range(0, 65535), $urandom_range(0, 1), 1'b1);
      end else if (r == 1) begin
        wait_for_pens();
      end else begin
        build_sequence();
        send_sequence(1'b1);
      end
    end
  endtask

  // The receiver holds off for a long stretch while words keep coming, so
  // the parser fills up and holds its input.
  task automatic test_output_stall();
    int first_word;
    first_word = words_sent;
    hold_asked++;
    while (words_sent - first_word < 40) begin
      build_sequence();
      send_sequence(1'b1);
    end
    wait_for_pens();
  endtask

  always @(posedge clk) begin
    if (hold_served != hold_asked) begin
      hold_served <= hold_asked;
      stall_left  <= LONG_HOLD;
      out_tready  <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      if (rx_cycle == '0) begin
        rx_mode <= $urandom_range(0, 3);
      end
      case (rx_mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= $urandom_range(0, 1);
        2:       out_tready <= (rx_cycle[1:0] == 2'd0);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
    rx_cycle <= rx_cycle + 1'b1;
  end

  function automatic void check_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_pens.size() == 0) begin
        $error("pen word with none expected: tdata %h tuser %h", out_tdata, out_tuser);
        mismatch_count++;
      end else begin
        got_pen = expected_pens.pop_front();
        check_field("style_bits", got_pen.style, out_tdata[5:0]);
        check_field("fg_kind", got_pen.fg.kind, out_tuser[1:0]);
        check_field("fg_red_or_index", got_pen.fg.c0, out_tdata[13:6]);
        check_field("fg_green", got_pen.fg.c1, out_tdata[21:14]);
        check_field("fg_blue", got_pen.fg.c2, out_tdata[29:22]);
        check_field("bg_kind", got_pen.bg.kind, out_tuser[3:2]);
        check_field("bg_red_or_index", got_pen.bg.c0, out_tdata[37:30]);
        check_field("bg_green", got_pen.bg.c1, out_tdata[45:38]);
        check_field("bg_blue", got_pen.bg.c2, out_tdata[53:46]);
        check_field("tdata padding", 0, out_tdata[55:54]);
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_sequence();
    test_style_and_palette();
    test_extended_forms();
    test_broken_forms();
    wait_for_pens();
    test_random_sequences(430);
    test_output_stall();
    test_random_sequences(430);
    wait_for_pens();
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
